[hw/rtl/hhrc_pkg.sv]
// Package for the hip height repetition counter: widths, register indexes,
// reset values, controller state and command/status structs. No dependencies.
`default_nettype none
package hhrc_pkg;
  localparam int unsigned WINDOW_DEPTH_DEF = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_WEIGHT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SWING     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LAND_RATIO    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TAKEOFF_RATIO = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN      = 3'd4;

  localparam logic [15:0] SMOOTH_WEIGHT_RST = 16'd58982;
  localparam logic [15:0] MIN_SWING_RST     = 16'd8520;
  localparam logic [15:0] LAND_RATIO_RST    = 16'd36045;
  localparam logic [15:0] TAKEOFF_RATIO_RST = 16'd22938;
  localparam logic [15:0] COOLDOWN_RST      = 16'd320;

  // spike rule: shoulder-hip distance above 30 px, jump above max(50 px, 0.35*sh)
  localparam logic signed [17:0] SPIKE_MIN_SH   = 18'sd480;
  localparam logic [16:0]        SPIKE_MIN_STEP = 17'd800;
  localparam logic [15:0]        SPIKE_SH_RATIO = 16'd22938;

  typedef enum logic [3:0] {
    ST_IDLE, ST_PUSH, ST_SCAN, ST_SMOOTH_TOP, ST_SMOOTH_BOT,
    ST_THRESH, ST_BOUNDS, ST_DECIDE, ST_OUT
  } hhrc_state_t;

  typedef struct packed {
    logic load;
    logic push;
    logic scan_clr;
    logic scan_step;
    logic smooth_top;
    logic smooth_bot;
    logic thresh;
    logic bounds;
    logic decide;
  } hhrc_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic pose;
  } hhrc_stat_t;
endpackage
`default_nettype wire

[hw/rtl/hip_height_repetition_counter_core.sv]
// Top level of the hip height repetition counter: controller plus datapath.
// Depends on hhrc_pkg, hhrc_ctrl and hhrc_dp.
//
//   channel | ports                  | moves
//   in      | in_valid / in_stall    | one frame transaction
//   out     | out_valid / out_stall  | one result transaction per frame
//   cfg     | cfg_we, cfg_index      | register write, no wait
//
// A frame with a pose runs the window scan, one entry per cycle, and then the
// smoothing, threshold, bounds and decide steps; a poseless frame skips them.
// Reset is synchronous, active low; the window needs no clearing pass.
// The next frame is taken only once the result transaction completes.
`default_nettype none
module hip_height_repetition_counter_core #(
  parameter int unsigned WINDOW_DEPTH = hhrc_pkg::WINDOW_DEPTH_DEF
) (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_stall,
  input  wire        in_pose_valid,
  input  wire [15:0] in_hip_left_y,
  input  wire [15:0] in_hip_right_y,
  input  wire [15:0] in_shoulder_left_y,
  input  wire [15:0] in_shoulder_right_y,
  input  wire [31:0] in_time_ms,
  output logic       out_valid,
  input  wire        out_stall,
  output logic       out_rep_counted,
  output logic [15:0] out_rep_total,
  output logic       out_landed_level,
  input  wire        cfg_we,
  input  wire [hhrc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire [hhrc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import hhrc_pkg::*;

  hhrc_cmd_t  cmd;
  hhrc_stat_t stat;

  hhrc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .cmd(cmd), .stat(stat)
  );

  hhrc_dp #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_pose_valid(in_pose_valid), .in_hip_left_y(in_hip_left_y),
    .in_hip_right_y(in_hip_right_y), .in_shoulder_left_y(in_shoulder_left_y),
    .in_shoulder_right_y(in_shoulder_right_y), .in_time_ms(in_time_ms),
    .out_rep_counted(out_rep_counted), .out_rep_total(out_rep_total),
    .out_landed_level(out_landed_level)
  );
endmodule
`default_nettype wire

[hw/rtl/hhrc_ctrl.sv]
// Controller for the repetition counter: sequences one frame through the
// datapath and runs the result handshake. Depends on hhrc_pkg.
`default_nettype none
module hhrc_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  wire                 out_stall,
  output hhrc_pkg::hhrc_cmd_t cmd,
  input  hhrc_pkg::hhrc_stat_t stat
);
  import hhrc_pkg::*;

  hhrc_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:       if (in_valid) state_nxt = ST_PUSH;
      ST_PUSH:       state_nxt = stat.pose ? ST_SCAN : ST_OUT;
      ST_SCAN:       if (stat.scan_done) state_nxt = ST_SMOOTH_TOP;
      ST_SMOOTH_TOP: state_nxt = ST_SMOOTH_BOT;
      ST_SMOOTH_BOT: state_nxt = ST_THRESH;
      ST_THRESH:     state_nxt = ST_BOUNDS;
      ST_BOUNDS:     state_nxt = ST_DECIDE;
      ST_DECIDE:     state_nxt = ST_OUT;
      ST_OUT:        if (!out_stall) state_nxt = ST_IDLE;
      default:       state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_PUSH: begin
        cmd.push = 1'b1;
        cmd.scan_clr = 1'b1;
      end
      ST_SCAN:       cmd.scan_step = 1'b1;
      ST_SMOOTH_TOP: cmd.smooth_top = 1'b1;
      ST_SMOOTH_BOT: cmd.smooth_bot = 1'b1;
      ST_THRESH:     cmd.thresh = 1'b1;
      ST_BOUNDS:     cmd.bounds = 1'b1;
      ST_DECIDE:     cmd.decide = 1'b1;
      ST_OUT:        out_valid = 1'b1;
      default: ;
    endcase
  end
endmodule
`default_nettype wire

[hw/rtl/hhrc_dp.sv]
// Datapath for the repetition counter: window memory, scan, smoothing,
// threshold tests and count state. Depends on hhrc_pkg.
`default_nettype none
module hhrc_dp #(
  parameter int unsigned WINDOW_DEPTH = hhrc_pkg::WINDOW_DEPTH_DEF
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  hhrc_pkg::hhrc_cmd_t  cmd,
  output hhrc_pkg::hhrc_stat_t stat,
  input  wire                  cfg_we,
  input  wire [hhrc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire [hhrc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire                  in_pose_valid,
  input  wire [15:0]           in_hip_left_y,
  input  wire [15:0]           in_hip_right_y,
  input  wire [15:0]           in_shoulder_left_y,
  input  wire [15:0]           in_shoulder_right_y,
  input  wire [31:0]           in_time_ms,
  output logic                 out_rep_counted,
  output logic [15:0]          out_rep_total,
  output logic                 out_landed_level
);
  import hhrc_pkg::*;

  localparam int unsigned AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int unsigned FW = $clog2(WINDOW_DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(WINDOW_DEPTH - 1);
  localparam logic [FW-1:0] DEPTH_F = FW'(WINDOW_DEPTH);

  // configuration registers
  logic [15:0] w_r, swing_r, land_r, takeoff_r, cool_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r <= SMOOTH_WEIGHT_RST;
      swing_r <= MIN_SWING_RST;
      land_r <= LAND_RATIO_RST;
      takeoff_r <= TAKEOFF_RATIO_RST;
      cool_r <= COOLDOWN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SMOOTH_WEIGHT: w_r <= cfg_data;
        REG_MIN_SWING:     swing_r <= cfg_data;
        REG_LAND_RATIO:    land_r <= cfg_data;
        REG_TAKEOFF_RATIO: takeoff_r <= cfg_data;
        REG_COOLDOWN:      cool_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // captured frame
  logic        pose_r;
  logic [15:0] cy_r;
  logic signed [17:0] sh_r;
  logic [31:0] now_r;
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pose_r <= in_pose_valid;
      cy_r <= 16'((17'(in_hip_left_y) + 17'(in_hip_right_y)) >> 1);
      sh_r <= 18'(signed'({1'b0, 16'((17'(in_hip_left_y) + 17'(in_hip_right_y)) >> 1)}))
            - 18'(signed'({1'b0, 16'((17'(in_shoulder_left_y)
                                     + 17'(in_shoulder_right_y)) >> 1)}));
      now_r <= in_time_ms;
    end
  end
  assign stat.pose = pose_r;

  // window memory; entries beyond the fill count are masked during the scan
  logic [15:0] win_mem [WINDOW_DEPTH];
  logic [AW-1:0] head_r;
  logic [FW-1:0] fill_r;
  logic [15:0] push_val;
  assign push_val = pose_r ? cy_r : 16'd0;

  always_ff @(posedge clk) begin
    if (cmd.push) win_mem[head_r] <= push_val;
  end

  // scan: address issued the cycle before the registered read
  logic [FW-1:0] addr_r;
  logic          rd_vld_r;
  logic [FW-1:0] rd_idx_r;
  logic [15:0]   rd_data_r;
  logic [15:0]   max_r, min_r;
  logic          found_r;
  logic          scan_fin_r;

  always_ff @(posedge clk) begin
    rd_data_r <= win_mem[addr_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
      scan_fin_r <= 1'b0;
    end else if (cmd.scan_clr) begin
      addr_r <= '0;
      rd_vld_r <= 1'b0;
      scan_fin_r <= 1'b0;
      max_r <= '0;
      min_r <= '0;
      found_r <= 1'b0;
    end else if (cmd.scan_step) begin
      rd_vld_r <= (addr_r < DEPTH_F);
      rd_idx_r <= addr_r;
      if (addr_r < DEPTH_F) addr_r <= addr_r + 1'b1;
      if (rd_vld_r && rd_idx_r < fill_r) begin
        if (rd_data_r > max_r) max_r <= rd_data_r;
        if (rd_data_r != 16'd0 && (!found_r || rd_data_r < min_r)) begin
          min_r <= rd_data_r;
          found_r <= 1'b1;
        end
      end
      scan_fin_r <= rd_vld_r && (rd_idx_r == DEPTH_F - 1'b1);
    end
  end
  assign stat.scan_done = scan_fin_r;

  // smoothing, one extreme per cycle through a shared pair of multipliers
  logic [31:0] top_r, bot_r;
  logic [15:0] raw_sel;
  logic [31:0] old_sel;
  logic [16:0] w_inv;
  logic [48:0] acc;
  logic [31:0] smoothed;
  assign raw_sel = cmd.smooth_top ? max_r : (found_r ? min_r : 16'd0);
  assign old_sel = cmd.smooth_top ? top_r : bot_r;
  assign w_inv = 17'd65536 - 17'(w_r);
  assign acc = 49'(w_r) * 49'({raw_sel, 16'd0}) + 49'(w_inv) * 49'(old_sel) + 49'd32768;
  assign smoothed = acc[47:16];

  // threshold and bounds products, registered
  logic signed [33:0] dy_r;
  logic signed [35:0] swing_thr_r;
  logic signed [51:0] land_p_r, take_p_r;

  logic        level_r, prev_valid_r, counted_once_r, counted_r;
  logic [15:0] prev_hip_r, total_r;
  logic [31:0] last_time_r;
  logic        spike_r;

  logic signed [17:0] jump;
  logic signed [35:0] step_a, step_b, step_max, jump_s;
  assign jump = 18'(signed'({1'b0, cy_r})) - 18'(signed'({1'b0, prev_hip_r}));
  assign step_a = 36'(SPIKE_MIN_STEP) <<< 16;
  assign step_b = 36'(signed'({1'b0, SPIKE_SH_RATIO})) * 36'(sh_r);
  assign step_max = (step_a > step_b) ? step_a : step_b;
  assign jump_s = 36'(jump < 0 ? -jump : jump) <<< 16;

  logic signed [51:0] cy_s, top_s, bot_s;
  assign cy_s = 52'(signed'({1'b0, cy_r})) <<< 32;
  assign top_s = 52'(signed'({1'b0, top_r})) <<< 16;
  assign bot_s = 52'(signed'({1'b0, bot_r})) <<< 16;

  logic        rise_nxt;
  logic        level_nxt;
  logic [31:0] elapsed;
  assign elapsed = now_r - last_time_r;

  always_comb begin
    level_nxt = level_r;
    if (!spike_r && dy_r > 34'(swing_thr_r)) begin
      if (!level_r && cy_s > top_s - land_p_r) level_nxt = 1'b1;
      else if (level_r && cy_s < bot_s + take_p_r) level_nxt = 1'b0;
    end
    rise_nxt = !level_r && level_nxt && !(counted_once_r && elapsed < 32'(cool_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      fill_r <= '0;
      top_r <= '0;
      bot_r <= '0;
      level_r <= 1'b1;
      prev_hip_r <= '0;
      prev_valid_r <= 1'b0;
      last_time_r <= '0;
      counted_once_r <= 1'b0;
      total_r <= '0;
      counted_r <= 1'b0;
      spike_r <= 1'b0;
    end else begin
      if (cmd.load) counted_r <= 1'b0;
      if (cmd.push) begin
        head_r <= (head_r == LAST_IDX) ? '0 : head_r + 1'b1;
        if (fill_r < DEPTH_F) fill_r <= fill_r + 1'b1;
        if (pose_r) begin
          spike_r <= prev_valid_r && (sh_r > SPIKE_MIN_SH) && (jump_s > step_max);
          prev_valid_r <= 1'b1;
          prev_hip_r <= cy_r;
          if (fill_r == '0 && cy_r != 16'd0) begin
            top_r <= {cy_r, 16'd0};
            bot_r <= {cy_r, 16'd0};
          end
        end
      end
      if (cmd.smooth_top) top_r <= smoothed;
      if (cmd.smooth_bot) bot_r <= smoothed;
      if (cmd.thresh) begin
        dy_r <= 34'(signed'({1'b0, top_r})) - 34'(signed'({1'b0, bot_r}));
        swing_thr_r <= 36'(signed'({1'b0, swing_r})) * 36'(sh_r);
      end
      if (cmd.bounds) begin
        land_p_r <= 52'(signed'({1'b0, land_r})) * 52'(dy_r);
        take_p_r <= 52'(signed'({1'b0, takeoff_r})) * 52'(dy_r);
      end
      if (cmd.decide) begin
        level_r <= level_nxt;
        if (rise_nxt) begin
          last_time_r <= now_r;
          counted_once_r <= 1'b1;
          counted_r <= 1'b1;
          if (total_r != 16'hFFFF) total_r <= total_r + 1'b1;
        end
      end
    end
  end

  assign out_rep_counted = counted_r;
  assign out_rep_total = total_r;
  assign out_landed_level = level_r;
endmodule
`default_nettype wire
